>>> hdl/text_window_cursor_writer_core_assert.svh
// assertion macros for the text window cursor core
`ifndef TEXT_WINDOW_CURSOR_WRITER_CORE_ASSERT_SVH
`define TEXT_WINDOW_CURSOR_WRITER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TWCW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("twcw assertion failed");

// next-cycle implication, checked outside reset
`define TWCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("twcw assertion failed");

`endif

>>> hdl/twcw_pkg.sv
package twcw_pkg;

  // cursor space limits
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 128;

  // control codes
  localparam logic [7:0] CODE_NUL = 8'd0;
  localparam logic [7:0] CODE_BEL = 8'd7;
  localparam logic [7:0] CODE_BS  = 8'd8;
  localparam logic [7:0] CODE_LF  = 8'd10;
  localparam logic [7:0] CODE_CR  = 8'd13;

  // item kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_SET  = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_WINDOW_LEFT    = 3'd0;
  localparam logic [2:0] REG_WINDOW_RIGHT   = 3'd1;
  localparam logic [2:0] REG_WINDOW_TOP     = 3'd2;
  localparam logic [2:0] REG_WINDOW_BOTTOM  = 3'd3;
  localparam logic [2:0] REG_CELL_ATTRIBUTE = 3'd4;
  localparam logic [2:0] REG_SCROLL_ENABLE  = 3'd5;

  typedef struct packed {
    logic [6:0]  window_left;
    logic [6:0]  window_right;
    logic [5:0]  window_top;
    logic [5:0]  window_bottom;
    logic [15:0] cell_attribute;
    logic        scroll_enable;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
    logic [5:0] set_row;
    logic [6:0] set_col;
  } item_t;

  typedef struct packed {
    logic        write_valid;
    logic [5:0]  write_row;
    logic [6:0]  write_col;
    logic [7:0]  write_char;
    logic [15:0] write_attr;
    logic        bell_pulse;
    logic        scroll_request;
    logic [5:0]  cursor_row;
    logic [6:0]  cursor_col;
  } res_t;

endpackage

>>> hdl/text_window_cursor_writer_core.sv
// Cursor engine for a text window on a character console. Each input
// transaction (a character, or a set-cursor command when s_tuser is 1) gives
// exactly one output transaction with the cell write, bell and scroll flags
// and the new cursor position. One item is taken per cycle unless m_tready
// stalls the output; an item passes the input register, then the output
// register. The rate is set by the cursor loop: the input register feeds the
// step logic, whose result loads the cursor registers and the output register
// in the same edge, so the next item already sees the updated cursor. Window
// registers are to be written through the cfg port while no item is in flight;
// the block does not enforce it. Writes to indexes above five are ignored.
module text_window_cursor_writer_core (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // item input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_code[7:0], set_row[13:8], set_col[20:14], zero
  input  logic        s_tuser,   // kind
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // write_valid[0], write_row[6:1], write_col[13:7],
                                 // write_char[21:14], write_attr[37:22],
                                 // bell_pulse[38], scroll_request[39],
                                 // cursor_row[45:40], cursor_col[52:46], zero
);

  twcw_pkg::cfg_t  cfg;
  twcw_pkg::item_t item;
  twcw_pkg::res_t  res_next;
  twcw_pkg::res_t  res;

  logic       item_valid;
  logic       out_free;
  logic       advance;
  logic [5:0] cur_row;
  logic [6:0] cur_col;

  // configuration registers
  twcw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // cursor update logic
  twcw_step u_step (
    .cfg     (cfg),
    .item    (item),
    .cur_row (cur_row),
    .cur_col (cur_col),
    .res     (res_next)
  );

  // pipeline flow
  assign out_free = !m_tvalid || m_tready;
  assign advance  = item_valid && out_free;
  assign s_tready = !item_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      item.kind      <= s_tuser;
      item.char_code <= s_tdata[7:0];
      item.set_row   <= s_tdata[13:8];
      item.set_col   <= s_tdata[20:14];
    end
  end

  // cursor state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row  <= 6'd0;
      cur_col  <= 7'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        cur_row <= res_next.cursor_row;
        cur_col <= res_next.cursor_col;
      end
      if (out_free) begin
        m_tvalid <= item_valid;
      end
    end
    if (advance) begin
      res <= res_next;
    end
  end

  // output packing
  assign m_tdata = {3'b000, res.cursor_col, res.cursor_row, res.scroll_request,
                    res.bell_pulse, res.write_attr, res.write_char, res.write_col,
                    res.write_row, res.write_valid};

`include "text_window_cursor_writer_core_assert.svh"

  `TWCW_ASSERT_NEXT(a_cursor_follows_result, advance,
    cur_row == res.cursor_row && cur_col == res.cursor_col)
  `TWCW_ASSERT_NOW(a_empty_stage_ready, !item_valid, s_tready)
  `TWCW_ASSERT_NOW(a_write_not_bell, m_tvalid && res.write_valid, !res.bell_pulse)
  `TWCW_ASSERT_NOW(a_idle_write_zero, m_tvalid && !res.write_valid,
    res.write_row == 6'd0 && res.write_col == 7'd0 && res.write_char == 8'd0 &&
    res.write_attr == 16'd0)

endmodule

>>> hdl/twcw_cfg.sv
module twcw_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output twcw_pkg::cfg_t      cfg
);

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register file, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_left    <= 7'd0;
      cfg.window_right   <= 7'd79;
      cfg.window_top     <= 6'd0;
      cfg.window_bottom  <= 6'd24;
      cfg.cell_attribute <= 16'd7;
      cfg.scroll_enable  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        twcw_pkg::REG_WINDOW_LEFT:    cfg.window_left    <= cfg_data[6:0];
        twcw_pkg::REG_WINDOW_RIGHT:   cfg.window_right   <= cfg_data[6:0];
        twcw_pkg::REG_WINDOW_TOP:     cfg.window_top     <= cfg_data[5:0];
        twcw_pkg::REG_WINDOW_BOTTOM:  cfg.window_bottom  <= cfg_data[5:0];
        twcw_pkg::REG_CELL_ATTRIBUTE: cfg.cell_attribute <= cfg_data;
        twcw_pkg::REG_SCROLL_ENABLE:  cfg.scroll_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/twcw_step.sv
module twcw_step (
  input  twcw_pkg::cfg_t  cfg,
  input  twcw_pkg::item_t item,
  input  logic [5:0]      cur_row,
  input  logic [6:0]      cur_col,
  output twcw_pkg::res_t  res
);

  localparam logic [7:0] ROW_LAST = 8'(twcw_pkg::MAX_ROWS - 1);
  localparam logic [7:0] COL_LAST = 8'(twcw_pkg::MAX_COLS - 1);

  // row and col carry headroom: row can reach two past the last row, col one past
  logic [7:0] row;
  logic [7:0] col;

  always_comb begin
    row = {2'b00, cur_row};
    col = {1'b0, cur_col};
    res = '0;

    if (item.kind == twcw_pkg::KIND_SET) begin
      // load position, clipped to the cursor space
      row = ({2'b00, item.set_row} > ROW_LAST) ? ROW_LAST : {2'b00, item.set_row};
      col = ({1'b0, item.set_col} > COL_LAST) ? COL_LAST : {1'b0, item.set_col};
    end else if (item.char_code != twcw_pkg::CODE_NUL) begin
      // control code or printable
      case (item.char_code)
        twcw_pkg::CODE_LF: row = row + 8'd1;
        twcw_pkg::CODE_CR: col = {1'b0, cfg.window_left};
        twcw_pkg::CODE_BS: begin
          if (col > {1'b0, cfg.window_left}) begin
            col = col - 8'd1;
          end else if (row > {2'b00, cfg.window_top}) begin
            row = row - 8'd1;
            col = {1'b0, cfg.window_right};
          end
        end
        twcw_pkg::CODE_BEL: res.bell_pulse = 1'b1;
        default: begin
          res.write_valid = 1'b1;
          res.write_row   = cur_row;
          res.write_col   = cur_col;
          res.write_char  = item.char_code;
          res.write_attr  = cfg.cell_attribute;
          col = col + 8'd1;
        end
      endcase

      // right edge wrap
      if (col > {1'b0, cfg.window_right}) begin
        col = {1'b0, cfg.window_left};
        row = row + 8'd1;
      end

      // bottom edge, one step back only
      if (row > {2'b00, cfg.window_bottom}) begin
        res.scroll_request = cfg.scroll_enable;
        row = row - 8'd1;
      end
    end

    res.cursor_row = row[5:0];
    res.cursor_col = col[6:0];
  end

endmodule

>>> dv/tb.sv
module tb;
  import twcw_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  // indexes past the register map, writes there must be dropped
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // char_code[7:0], set_row[13:8], set_col[20:14], zero
  logic        s_tuser = 1'b0; // kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;        // write_valid[0], write_row[6:1], write_col[13:7],
                               // write_char[21:14], write_attr[37:22],
                               // bell_pulse[38], scroll_request[39],
                               // cursor_row[45:40], cursor_col[52:46], zero

  text_window_cursor_writer_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #5 clk = ~clk;

  // predicted window settings and cursor
  logic [6:0]  win_left = 7'd0;
  logic [6:0]  win_right = 7'd79;
  logic [5:0]  win_top = 6'd0;
  logic [5:0]  win_bottom = 6'd24;
  logic [15:0] cell_attr = 16'd7;
  logic        scroll_en = 1'b1;
  logic [5:0]  pred_row = '0;
  logic [6:0]  pred_col = '0;

  res_t pending_updates[$];
  int   errors = 0;
  int   cycle_count = 0;
  int   src_idle_pct = 0;
  int   snk_stall_pct = 0;

  // cursor step for one accepted item, updates the predicted cursor
  function automatic res_t step_cursor(item_t it);
    res_t r;
    int   row;
    int   col;
    r = '0;
    row = int'(pred_row);
    col = int'(pred_col);
    if (it.kind == KIND_SET) begin
      row = (int'(it.set_row) < MAX_ROWS) ? int'(it.set_row) : MAX_ROWS - 1;
      col = (int'(it.set_col) < MAX_COLS) ? int'(it.set_col) : MAX_COLS - 1;
    end else if (it.char_code != CODE_NUL) begin
      case (it.char_code)
        CODE_LF: row++;
        CODE_CR: col = int'(win_left);
        CODE_BS: begin
          if (col > int'(win_left)) begin
            col--;
          end else if (row > int'(win_top)) begin
            row--;
            col = int'(win_right);
          end
        end
        CODE_BEL: r.bell_pulse = 1'b1;
        default: begin
          r.write_valid = 1'b1;
          r.write_row   = row[5:0];
          r.write_col   = col[6:0];
          r.write_char  = it.char_code;
          r.write_attr  = cell_attr;
          col++;
        end
      endcase
      // right edge wrap, then a single step back from below the bottom row
      if (col > int'(win_right)) begin
        col = int'(win_left);
        row++;
      end
      if (row > int'(win_bottom)) begin
        r.scroll_request = scroll_en;
        row--;
      end
    end
    pred_row = row[5:0];
    pred_col = col[6:0];
    r.cursor_row = pred_row;
    r.cursor_col = pred_col;
    return r;
  endfunction

  // receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // compare each output transaction with the oldest predicted update
  always @(posedge clk) begin
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_updates.size() == 0) begin
        $error("result transaction with no predicted update: %h", m_tdata);
        errors++;
      end else begin
        want = pending_updates.pop_front();
        check_field("write_valid", want.write_valid, m_tdata[0]);
        check_field("write_row", want.write_row, m_tdata[6:1]);
        check_field("write_col", want.write_col, m_tdata[13:7]);
        check_field("write_char", want.write_char, m_tdata[21:14]);
        check_field("write_attr", want.write_attr, m_tdata[37:22]);
        check_field("bell_pulse", want.bell_pulse, m_tdata[38]);
        check_field("scroll_request", want.scroll_request, m_tdata[39]);
        check_field("cursor_row", want.cursor_row, m_tdata[45:40]);
        check_field("cursor_col", want.cursor_col, m_tdata[52:46]);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic kind, input logic [7:0] code,
                           input logic [5:0] row, input logic [6:0] col);
    item_t it;
    it.kind = kind;
    it.char_code = code;
    it.set_row = row;
    it.set_col = col;
    // random sender gaps
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {3'b000, col, row, code};
    do @(posedge clk); while (!s_tready);
    pending_updates.push_back(step_cursor(it));
  endtask

  task automatic send_char(input logic [7:0] code);
    send_item(KIND_CHAR, code, 6'($urandom), 7'($urandom));
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WINDOW_LEFT:    win_left = val[6:0];
      REG_WINDOW_RIGHT:   win_right = val[6:0];
      REG_WINDOW_TOP:     win_top = val[5:0];
      REG_WINDOW_BOTTOM:  win_bottom = val[5:0];
      REG_CELL_ATTRIBUTE: cell_attr = val;
      REG_SCROLL_ENABLE:  scroll_en = val[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // all six registers, junk in the unused upper data bits
  task automatic set_window(input logic [6:0] l, input logic [6:0] r,
                            input logic [5:0] t, input logic [5:0] b,
                            input logic [15:0] attr, input logic scroll);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_reg(REG_WINDOW_LEFT, {junk[15:7], l});
    write_reg(REG_WINDOW_RIGHT, {junk[8:0], r});
    write_reg(REG_WINDOW_TOP, {junk[15:6], t});
    write_reg(REG_WINDOW_BOTTOM, {junk[9:0], b});
    write_reg(REG_CELL_ATTRIBUTE, attr);
    write_reg(REG_SCROLL_ENABLE, {junk[14:0], scroll});
  endtask

  task automatic random_window();
    logic [6:0] l;
    logic [6:0] r;
    logic [5:0] t;
    logic [5:0] b;
    l = 7'($urandom);
    r = 7'($urandom);
    t = 6'($urandom);
    b = 6'($urandom);
    case ($urandom_range(4))
      0: begin
        l = 7'd0; r = 7'd79; t = 6'd0; b = 6'd24;
      end
      1: begin
        l = 7'd0; r = 7'd127; t = 6'd0; b = 6'd63;
      end
      2: begin
        if (l > r) {l, r} = {r, l};
        if (t > b) {t, b} = {b, t};
      end
      3: begin
        r = l;
        b = t;
      end
      default: ; // anything, inverted windows included
    endcase
    set_window(l, r, t, b, 16'($urandom), 1'($urandom));
  endtask

  // mostly cursor traffic inside the window, some jumps anywhere
  task automatic send_random_item();
    int sel;
    sel = $urandom_range(99);
    if (sel < 9)
      send_item(KIND_SET, 8'($urandom), 6'($urandom_range(win_top, win_bottom)),
                7'($urandom_range(win_left, win_right)));
    else if (sel < 13)
      send_item(KIND_SET, 8'($urandom), 6'($urandom), 7'($urandom));
    else if (sel < 27)
      send_char(CODE_LF);
    else if (sel < 34)
      send_char(CODE_CR);
    else if (sel < 45)
      send_char(CODE_BS);
    else if (sel < 48)
      send_char(CODE_BEL);
    else if (sel < 51)
      send_char(CODE_NUL);
    else
      send_char(8'($urandom));
  endtask

  task automatic run_traffic(input int n_items);
    for (int chunk = 0; chunk < 3; chunk++) begin
      wait_drain();
      random_window();
      for (int i = 0; i < n_items / 3; i++) send_random_item();
    end
  endtask

  // control codes and cursor extremes with the reset window
  task automatic test_control_codes();
    send_char(8'h41);
    send_char(8'hFF);
    send_char(CODE_BEL);
    send_char(CODE_NUL);
    send_char(CODE_BS);
    send_char(CODE_CR);
    send_char(CODE_BS);       // left edge on the top row, stays
    send_char(CODE_LF);
    send_char(CODE_BS);       // left edge below the top, end of the row above
    send_item(KIND_SET, 8'hFF, 6'd24, 7'd79);
    send_char(8'h78);         // wrap past the bottom corner
    send_char(CODE_LF);       // line feed on the bottom row
    send_item(KIND_SET, 8'h00, 6'd63, 7'd127);
    send_char(CODE_LF);       // below the window and past the right edge
    send_item(KIND_SET, 8'h0A, 6'd63, 7'd127);
    send_char(8'h20);
  endtask

  // custom, single row and inverted windows, scroll disabled
  task automatic test_window_regs();
    wait_drain();
    set_window(7'd10, 7'd20, 6'd5, 6'd8, 16'hFFFF, 1'b0);
    send_item(KIND_SET, 8'h00, 6'd8, 7'd20);
    send_char(8'h7E);         // overflow with scrolling off
    send_item(KIND_SET, 8'h00, 6'd5, 7'd10);
    send_char(CODE_BS);
    send_char(CODE_CR);
    wait_drain();
    set_window(7'd50, 7'd40, 6'd0, 6'd0, 16'h0000, 1'b1);
    send_char(8'h80);
    send_char(CODE_BS);
    send_char(CODE_LF);
    wait_drain();
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'hFFFF);
    send_char(8'h55);
  endtask

  task automatic test_no_idle();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    run_traffic(150);
  endtask

  task automatic test_sender_gaps();
    src_idle_pct = 65;
    snk_stall_pct = 0;
    run_traffic(150);
  endtask

  task automatic test_receiver_stalls();
    src_idle_pct = 0;
    snk_stall_pct = 65;
    run_traffic(150);
  endtask

  task automatic test_mixed_gaps();
    src_idle_pct = 20;
    snk_stall_pct = 20;
    run_traffic(150);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_control_codes();
    test_window_regs();
    test_no_idle();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_gaps();
    wait_drain();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
